// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the indexed max-priority table.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("imptab assertion failed");

// Checks that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("imptab forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: rtl/core/imptab_pkg.sv
// Shared types and constants of the indexed max-priority table.
// No dependencies; imported by the top level.
package imptab_pkg;

   // Fixed field widths of the request and response beats and of the arrival stamp.
   localparam int MODE_W  = 2;
   localparam int ID_W    = 6;
   localparam int VALUE_W = 8;
   localparam int STAMP_W = 16;

   // Command codes carried in req_mode.
   localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAISE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LEAVE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RAISE = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

// File: rtl/core/imptab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the entry table of the top level.
module imptab_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/indexed_max_priority_table.sv
// Indexed max-priority table: arrive, raise, leave and query-top on entries by id.
// Arrive and leave write the entry on accept; raise reads the entry, then writes it.
// A query walks the table RAM with one comparator, one entry per cycle, then loads the
// response once the previous beat is gone and goes back to idle as rsp_valid rises.
// After reset a clearing pass zeroes every RAM entry; req_ready stays low meanwhile.
// Depends on imptab_pkg, imptab_ram and assert_macros.svh.
`include "assert_macros.svh"

module indexed_max_priority_table #(
   parameter int NUM_ENTRIES = 64,
   parameter int LEVEL_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [imptab_pkg::MODE_W-1:0]   req_mode,
   input  logic [imptab_pkg::ID_W-1:0]     req_entry_id,
   input  logic [imptab_pkg::VALUE_W-1:0]  req_level_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [imptab_pkg::ID_W-1:0]     rsp_top_id
);

   import imptab_pkg::*;

   localparam int IDX_W  = $clog2(NUM_ENTRIES);
   localparam int WORD_W = 1 + LEVEL_BITS + STAMP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [STAMP_W-1:0]      stamp_ff, stamp_in;
   logic [IDX_W-1:0]        cmd_addr_ff, cmd_addr_in;
   logic [LEVEL_BITS-1:0]   cmd_value_ff, cmd_value_in;
   logic                    have_ff, have_in;
   logic [LEVEL_BITS-1:0]   best_level_ff, best_level_in;
   logic [STAMP_W-1:0]      best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0]        best_id_ff, best_id_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [ID_W-1:0]         rsp_top_id_ff, rsp_top_id_in;

   logic                    req_fire;
   logic                    req_in_range;
   logic [IDX_W-1:0]        req_addr;
   logic [LEVEL_BITS-1:0]   req_level;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [WORD_W-1:0]       wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [WORD_W-1:0]       rd_data;

   logic                    rd_valid;
   logic [LEVEL_BITS-1:0]   rd_level;
   logic [STAMP_W-1:0]      rd_stamp;
   logic                    better;
   logic [LEVEL_BITS:0]     sum_wide;
   logic [LEVEL_BITS-1:0]   raised_level;

   // Entry table: {valid, level, arrival stamp} per id.
   imptab_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request decode.
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid & req_ready;
   assign req_in_range = (32'(req_entry_id) < 32'(NUM_ENTRIES));
   assign req_addr     = IDX_W'(req_entry_id);
   assign req_level    = LEVEL_BITS'(req_level_value);

   // Fields of the word coming out of the table.
   assign rd_valid = rd_data[WORD_W-1];
   assign rd_level = rd_data[STAMP_W +: LEVEL_BITS];
   assign rd_stamp = rd_data[STAMP_W-1:0];

   // Scan comparator: higher level wins, then the earlier stamp; ties keep the lower id.
   assign better = rd_valid &&
                   (!have_ff || (rd_level > best_level_ff) ||
                    ((rd_level == best_level_ff) && (rd_stamp < best_stamp_ff)));

   // Saturating add for raise.
   assign sum_wide     = {1'b0, rd_level} + {1'b0, cmd_value_ff};
   assign raised_level = sum_wide[LEVEL_BITS] ? {LEVEL_BITS{1'b1}} : sum_wide[LEVEL_BITS-1:0];

   // Sequencer and table port control.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      stamp_in      = stamp_ff;
      cmd_addr_in   = cmd_addr_ff;
      cmd_value_in  = cmd_value_ff;
      have_in       = have_ff;
      best_level_in = best_level_ff;
      best_stamp_in = best_stamp_ff;
      best_id_in    = best_id_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_top_id_in = rsp_top_id_ff;
      wr_en         = 1'b0;
      wr_addr       = cmd_addr_ff;
      wr_data       = '0;
      rd_addr       = req_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            cmd_addr_in  = req_addr;
            cmd_value_in = req_level;
            if (req_mode == MODE_QUERY) begin
               rd_addr = '0;
            end
            if (req_fire) begin
               unique case (req_mode)
                  MODE_ARRIVE: begin
                     if (req_in_range) begin
                        wr_en    = 1'b1;
                        wr_addr  = req_addr;
                        wr_data  = {1'b1, req_level, stamp_ff};
                        stamp_in = (stamp_ff == {STAMP_W{1'b1}}) ? stamp_ff
                                                                  : stamp_ff + 1'b1;
                     end
                  end
                  MODE_RAISE: begin
                     if (req_in_range) begin
                        state_in = ST_RAISE;
                     end
                  end
                  MODE_LEAVE: begin
                     if (req_in_range) begin
                        wr_en   = 1'b1;
                        wr_addr = req_addr;
                        wr_data = '0;
                     end
                  end
                  MODE_QUERY: begin
                     idx_in     = '0;
                     have_in    = 1'b0;
                     best_id_in = '0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_RAISE: begin
            // Read data of the addressed entry arrived this cycle.
            if (rd_valid) begin
               wr_en   = 1'b1;
               wr_addr = cmd_addr_ff;
               wr_data = {1'b1, raised_level, rd_stamp};
            end
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            // rd_data holds entry idx_ff; fetch the next one meanwhile.
            rd_addr = idx_ff + 1'b1;
            if (better) begin
               have_in       = 1'b1;
               best_level_in = rd_level;
               best_stamp_in = rd_stamp;
               best_id_in    = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_DONE: begin
            // Load the response register once the previous beat is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = have_ff;
               rsp_top_id_in = ID_W'(best_id_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         stamp_ff     <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         stamp_ff     <= stamp_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_addr_ff   <= cmd_addr_in;
      cmd_value_ff  <= cmd_value_in;
      best_level_ff <= best_level_in;
      best_stamp_ff <= best_stamp_in;
      best_id_ff    <= best_id_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_top_id_ff <= rsp_top_id_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_top_id = rsp_top_id_ff;

   // A query beat always starts the table walk.
   `ASSERT_PROP(a_query_starts_scan, clock, reset, (req_valid && req_ready && (req_mode == MODE_QUERY)) |=> (state_ff == ST_SCAN))
   // The walk index never leaves the table.
   `ASSERT_PROP(a_scan_idx_range, clock, reset, (state_ff == ST_SCAN) |-> (32'(idx_ff) < 32'(NUM_ENTRIES)))
   // An empty answer carries id zero.
   `ASSERT_PROP(a_empty_id_zero, clock, reset, (rsp_valid && !rsp_found) |-> (rsp_top_id == '0))
   // A new response beat only comes out of the final walk step.
   `ASSERT_PROP(a_rsp_from_done, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
   // No request is taken during the clearing pass.
   `ASSERT_NEVER(a_no_req_in_clear, clock, reset, (state_ff == ST_CLEAR) && req_ready)

endmodule

// File: tb/sv/imptab_checker.sv
// Scoreboard for the indexed max-priority table: it keeps a shadow copy of the table,
// predicts every query response from it and compares the response beats field by field.
// Depends on imptab_pkg.
module imptab_checker #(
   parameter int NUM_ENTRIES = 64,
   parameter int LEVEL_BITS  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [imptab_pkg::MODE_W-1:0]  req_mode,
   input  logic [imptab_pkg::ID_W-1:0]    req_entry_id,
   input  logic [imptab_pkg::VALUE_W-1:0] req_level_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_found,
   input  logic [imptab_pkg::ID_W-1:0]    rsp_top_id,
   output int                             mismatch_count,
   output int                             outstanding,
   output int                             responses_checked
);

   import imptab_pkg::*;

   typedef struct packed {
      logic            found;
      logic [ID_W-1:0] top_id;
   } top_answer_type;

   // Shadow copy of the table and of the arrival counter.
   logic                  shadow_valid [NUM_ENTRIES];
   logic [LEVEL_BITS-1:0] shadow_level [NUM_ENTRIES];
   logic [STAMP_W-1:0]    shadow_stamp [NUM_ENTRIES];
   logic [STAMP_W-1:0]    arrival_count;

   // Answers still owed by the block, oldest first.
   top_answer_type pending_tops [$];

   int mismatches = 0;
   int checked    = 0;

   // Highest level wins; equal levels go to the earlier stamp, then to the lower id.
   function automatic top_answer_type scan_for_top();
      top_answer_type        answer;
      logic [LEVEL_BITS-1:0] best_level;
      logic [STAMP_W-1:0]    best_stamp;
      answer     = '0;
      best_level = '0;
      best_stamp = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (shadow_valid[i] && (!answer.found || shadow_level[i] > best_level ||
             (shadow_level[i] == best_level && shadow_stamp[i] < best_stamp))) begin
            answer.found  = 1'b1;
            answer.top_id = ID_W'(i);
            best_level    = shadow_level[i];
            best_stamp    = shadow_stamp[i];
         end
      end
      return answer;
   endfunction

   // Arrive, raise and leave change the shadow table and owe no response.
   task automatic apply_update(input logic [MODE_W-1:0]  mode,
                               input logic [ID_W-1:0]    id,
                               input logic [VALUE_W-1:0] value);
      logic [LEVEL_BITS-1:0] amount;
      logic [LEVEL_BITS:0]   sum;
      amount = LEVEL_BITS'(value);
      if (int'(id) < NUM_ENTRIES) begin
         case (mode)
            MODE_ARRIVE: begin
               shadow_level[id] = amount;
               shadow_valid[id] = 1'b1;
               shadow_stamp[id] = arrival_count;
               // The counter sticks at its maximum once it gets there.
               if (arrival_count != '1) begin
                  arrival_count = arrival_count + 1'b1;
               end
            end
            MODE_RAISE: begin
               if (shadow_valid[id]) begin
                  sum = {1'b0, shadow_level[id]} + {1'b0, amount};
                  shadow_level[id] = sum[LEVEL_BITS] ? '1 : sum[LEVEL_BITS-1:0];
               end
            end
            MODE_LEAVE: begin
               shadow_valid[id] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   endtask

   // Watch both channels at each rising edge: request beats first, then responses.
   always @(posedge clock) begin
      top_answer_type owed;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_level[i] = '0;
            shadow_stamp[i] = '0;
         end
         arrival_count = '0;
         pending_tops.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_mode == MODE_QUERY) begin
               pending_tops.insert(pending_tops.size(), scan_for_top());
            end else begin
               apply_update(req_mode, req_entry_id, req_level_value);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_tops.size() == 0) begin
               mismatches++;
               $display("%0t: response beat with no query waiting: found %0b, top_id %0d",
                        $time, rsp_found, rsp_top_id);
            end else begin
               owed = pending_tops.pop_front();
               checked++;
               if (rsp_found !== owed.found) begin
                  mismatches++;
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, owed.found, rsp_found);
               end
               if (rsp_top_id !== owed.top_id) begin
                  mismatches++;
                  $display("%0t: top_id mismatch: expected %0d, actual %0d",
                           $time, owed.top_id, rsp_top_id);
               end
            end
         end
      end
      mismatch_count    <= mismatches;
      outstanding       <= pending_tops.size();
      responses_checked <= checked;
   end

endmodule

// File: tb/sv/indexed_max_priority_table_tb.sv
// Testbench top for the indexed max-priority table: drives request beats and response
// back-pressure, instantiates the block and its scoreboard, and gives the verdict.
// Depends on imptab_pkg, imptab_checker and the indexed_max_priority_table RTL.
module indexed_max_priority_table_tb;
   import imptab_pkg::*;

   localparam int NUM_ENTRIES = 64;
   localparam int LEVEL_BITS  = 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_CYCLES = 400;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [MODE_W-1:0]  req_mode;
   logic [ID_W-1:0]    req_entry_id;
   logic [VALUE_W-1:0] req_level_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_found;
   logic [ID_W-1:0]    rsp_top_id;

   int mismatch_count;
   int outstanding;
   int responses_checked;
   int cycle_count = 0;
   int beats_by_mode [4] = '{0, 0, 0, 0};
   bit hold_wanted = 1'b0;
   bit hold_served = 1'b0;
   bit sender_calm = 1'b0;

   indexed_max_priority_table #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .LEVEL_BITS (LEVEL_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_entry_id   (req_entry_id),
      .req_level_value(req_level_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_top_id     (rsp_top_id)
   );

   imptab_checker #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .LEVEL_BITS (LEVEL_BITS)
   ) top_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_id     (req_entry_id),
      .req_level_value  (req_level_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_top_id       (rsp_top_id),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .responses_checked(responses_checked)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly no gap, some short gaps and a few long ones; none during a calm spell.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Ids lean on a few corners so that entries get revisited and levels tie often.
   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 1) == 0) begin
         return ID_W'($urandom_range(0, NUM_ENTRIES - 1));
      end else if ($urandom_range(0, 1) == 0) begin
         return ID_W'($urandom_range(0, 3));
      end
      return ID_W'($urandom_range(NUM_ENTRIES - 4, NUM_ENTRIES - 1));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return VALUE_W'($urandom_range(0, 3));
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         return MODE_ARRIVE;
      end else if (roll < 55) begin
         return MODE_RAISE;
      end else if (roll < 75) begin
         return MODE_LEAVE;
      end
      return MODE_QUERY;
   endfunction

   // Offer one request beat after an optional gap and hold it until accepted.
   task automatic offer(input logic [MODE_W-1:0]  mode,
                        input logic [ID_W-1:0]    id,
                        input logic [VALUE_W-1:0] value,
                        input int                 gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_id    <= id;
      req_level_value <= value;
      do @(posedge clock); while (!req_ready);
      beats_by_mode[int'(mode)]++;
   endtask

   task automatic random_beats(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
         end
         offer(pick_mode(), pick_id(), pick_level(), pick_gap());
      end
   endtask

   // Response side: random back-pressure, calm spells, and one long hold-off on request.
   initial begin : rsp_side
      int gap_left;
      int calm_left;
      gap_left  = 0;
      calm_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (calm_left > 0) begin
            rsp_ready <= 1'b1;
            calm_left--;
         end else if (gap_left > 0) begin
            rsp_ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ready <= 1'b1;
            case ($urandom_range(0, 15))
               0:       gap_left  = $urandom_range(20, 80);
               1:       calm_left = $urandom_range(100, 300);
               2, 3, 4: gap_left  = $urandom_range(1, 3);
               default: begin
               end
            endcase
         end
      end
   end

   // Request side: directed corners, random traffic, a full sweep of leaves, more traffic.
   initial begin : req_side
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_ARRIVE;
      req_entry_id    <= '0;
      req_level_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then raise and leave on entries that were never valid.
      offer(MODE_QUERY, '0, '0, pick_gap());
      offer(MODE_LEAVE, ID_W'(5), '0, pick_gap());
      offer(MODE_RAISE, ID_W'(5), VALUE_W'(10), pick_gap());
      offer(MODE_QUERY, '1, '1, pick_gap());
      // Lowest and highest id and level.
      offer(MODE_ARRIVE, '0, '0, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      offer(MODE_ARRIVE, '1, '1, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      // A later arrival at the same level loses the tie.
      offer(MODE_ARRIVE, ID_W'(10), '1, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      // Raise past the maximum saturates.
      offer(MODE_RAISE, '1, '1, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      // Arriving again overwrites the level and takes a fresh stamp.
      offer(MODE_ARRIVE, '1, VALUE_W'(1), pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      // Climb entry 0 to the top level; its early stamp wins the tie with entry 10.
      offer(MODE_RAISE, '0, VALUE_W'(254), pick_gap());
      offer(MODE_RAISE, '0, VALUE_W'(1), pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      offer(MODE_LEAVE, '0, '0, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());
      // Alternating bit patterns, then leave everything and query the empty table.
      offer(MODE_ARRIVE, ID_W'(6'h2A), VALUE_W'(8'hAA), pick_gap());
      offer(MODE_ARRIVE, ID_W'(6'h15), VALUE_W'(8'h55), pick_gap());
      offer(MODE_LEAVE, ID_W'(10), '0, pick_gap());
      offer(MODE_LEAVE, ID_W'(6'h2A), '0, pick_gap());
      offer(MODE_LEAVE, ID_W'(6'h15), '0, pick_gap());
      offer(MODE_LEAVE, '1, '0, pick_gap());
      offer(MODE_QUERY, '0, '0, pick_gap());

      // Random traffic; the response side stalls for a long stretch right at its start.
      hold_wanted = 1'b1;
      random_beats(1060);

      // Empty the whole table, check it reads empty, then refill it at random.
      sender_calm = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         offer(MODE_LEAVE, ID_W'(i), pick_level(), pick_gap());
      end
      offer(MODE_QUERY, '0, '0, pick_gap());
      random_beats(300);
      req_valid <= 1'b0;

      // Drain the owed responses, then watch a little longer for stray beats.
      do @(posedge clock); while (outstanding != 0);
      repeat (NUM_ENTRIES + 8) @(posedge clock);

      $display("Sent %0d arrive, %0d raise, %0d leave and %0d query beats,",
               beats_by_mode[int'(MODE_ARRIVE)], beats_by_mode[int'(MODE_RAISE)],
               beats_by_mode[int'(MODE_LEAVE)], beats_by_mode[int'(MODE_QUERY)]);
      $display("with random gaps and one long response hold-off; %0d responses compared.",
               responses_checked);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
